@@ design/lpac_pkg.sv @@
// shared types and constants for the paged array controller
// no dependencies
package lpac_pkg;

  localparam int IDX_W    = 24;
  localparam int PSIZE_W  = 15;
  localparam int OFF_W    = 14;
  localparam int NSLOT_W  = 5;
  localparam int SLOTO_W  = 4;
  localparam int VICT_W   = 10;
  localparam int CNT_W    = 48;
  localparam int CFGIDX_W = 4;
  localparam int DIVCNT_W = 5;

  localparam logic [PSIZE_W-1:0] PSIZE_MAX   = 15'd16384;
  localparam logic [PSIZE_W-1:0] PSIZE_RST   = 15'd256;
  localparam logic [NSLOT_W-1:0] NSLOT_RST   = 5'd16;
  localparam logic [CFGIDX_W-1:0] REG_PSIZE  = 4'd0;
  localparam logic [CFGIDX_W-1:0] REG_NSLOTS = 4'd1;
  localparam logic [DIVCNT_W-1:0] DIV_LAST   = 5'(IDX_W - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX     = {CNT_W{1'b1}};

  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ design/lru_paged_array_controller.sv @@
// top level of the paged array controller: configuration registers,
// sequencer and datapath; depends on lpac_pkg, lpac_ctrl, lpac_dp
//
// channel   ports                              handshake
// in        in_element_index                   in_valid / in_stall
// out       out_page_number .. out_out_of_range out_valid / out_stall
// cfg       cfg_index, cfg_data                cfg_valid / cfg_ready
//
// one item passes through load, divide, slot scan and commit:
// 24 steps of the one-bit restoring divider, then one slot per cycle in the scan
// a new item is taken while the previous result still waits in the output register
// the commit waits while a held result is stalled
// reset clears slot valid, dirty and stamp state, stamp clock, counters and configuration
module lru_paged_array_controller #(
  parameter int NUM_SLOTS  = 16,
  parameter int MAX_PAGES  = 1024,
  parameter int STAMP_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lpac_pkg::IDX_W-1:0]          in_element_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lpac_pkg::IDX_W-1:0]          out_page_number,
  output logic [lpac_pkg::OFF_W-1:0]          out_page_offset,
  output logic [lpac_pkg::SLOTO_W-1:0]        out_ram_slot,
  output logic                                out_was_hit,
  output logic                                out_load_needed,
  output logic                                out_writeback_needed,
  output logic [lpac_pkg::VICT_W-1:0]         out_victim_page,
  output logic [lpac_pkg::CNT_W-1:0]          out_hit_total,
  output logic [lpac_pkg::CNT_W-1:0]          out_fault_total,
  output logic                                out_out_of_range,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpac_pkg::CFGIDX_W-1:0]       cfg_index,
  input  logic [lpac_pkg::PSIZE_W-1:0]        cfg_data
);

  logic [lpac_pkg::PSIZE_W-1:0] psize_r;
  logic [lpac_pkg::NSLOT_W-1:0] nslots_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r  <= lpac_pkg::PSIZE_RST;
      nslots_r <= lpac_pkg::NSLOT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == lpac_pkg::REG_PSIZE)  psize_r  <= cfg_data;
      if (cfg_index == lpac_pkg::REG_NSLOTS) nslots_r <= cfg_data[lpac_pkg::NSLOT_W-1:0];
    end
  end

  lpac_pkg::dp_cmd_t cmd;
  lpac_pkg::dp_sts_t sts;

  lpac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpac_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .MAX_PAGES  (MAX_PAGES),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_element_index     (in_element_index),
    .page_size            (psize_r),
    .slots_in_use         (nslots_r),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_page_number      (out_page_number),
    .out_page_offset      (out_page_offset),
    .out_ram_slot         (out_ram_slot),
    .out_was_hit          (out_was_hit),
    .out_load_needed      (out_load_needed),
    .out_writeback_needed (out_writeback_needed),
    .out_victim_page      (out_victim_page),
    .out_hit_total        (out_hit_total),
    .out_fault_total      (out_fault_total),
    .out_out_of_range     (out_out_of_range)
  );

endmodule

@@ design/lpac_ctrl.sv @@
// sequencer for one access: divide, slot scan, commit
// depends on lpac_pkg
module lpac_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lpac_pkg::dp_sts_t  sts,
  output lpac_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIV    = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

@@ design/lpac_dp.sv @@
// datapath: restoring divider, slot registers, lru scan, counters, result register
// depends on lpac_pkg
module lpac_dp #(
  parameter int NUM_SLOTS  = 16,
  parameter int MAX_PAGES  = 1024,
  parameter int STAMP_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lpac_pkg::dp_cmd_t                  cmd,
  output lpac_pkg::dp_sts_t                  sts,
  input  logic [lpac_pkg::IDX_W-1:0]         in_element_index,
  input  logic [lpac_pkg::PSIZE_W-1:0]       page_size,
  input  logic [lpac_pkg::NSLOT_W-1:0]       slots_in_use,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic [lpac_pkg::IDX_W-1:0]         out_page_number,
  output logic [lpac_pkg::OFF_W-1:0]         out_page_offset,
  output logic [lpac_pkg::SLOTO_W-1:0]       out_ram_slot,
  output logic                               out_was_hit,
  output logic                               out_load_needed,
  output logic                               out_writeback_needed,
  output logic [lpac_pkg::VICT_W-1:0]        out_victim_page,
  output logic [lpac_pkg::CNT_W-1:0]         out_hit_total,
  output logic [lpac_pkg::CNT_W-1:0]         out_fault_total,
  output logic                               out_out_of_range
);

  localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NW  = $clog2(NUM_SLOTS + 1) + 1;
  localparam int PW  = $clog2(MAX_PAGES);
  localparam logic [SW-1:0] SLOT_LAST = SW'(NUM_SLOTS - 1);
  localparam logic [lpac_pkg::IDX_W-1:0] PAGE_LIM = lpac_pkg::IDX_W'(MAX_PAGES);

  // access registers
  logic [lpac_pkg::IDX_W-1:0]    quo_r;      // index, shifted into quotient
  logic [lpac_pkg::OFF_W-1:0]    rem_r;
  logic [lpac_pkg::PSIZE_W-1:0]  ps_r;
  logic [NW-1:0]                 ns_r;
  logic [lpac_pkg::DIVCNT_W-1:0] dcnt_r;
  logic [SW-1:0]                 sidx_r;

  // scan results
  logic           hit_r, free_r;
  logic [SW-1:0]  hslot_r, fslot_r, bslot_r;
  logic [STAMP_BITS-1:0] best_r;
  logic [PW-1:0]  bpage_r;
  logic           bdirty_r;

  // slot state
  logic                  sp_valid_r [NUM_SLOTS];
  logic [PW-1:0]         sp_page_r  [NUM_SLOTS];
  logic                  sp_dirty_r [NUM_SLOTS];
  logic [STAMP_BITS-1:0] sp_stamp_r [NUM_SLOTS];
  logic [STAMP_BITS-1:0] clock_r;
  logic [lpac_pkg::CNT_W-1:0] hits_r, faults_r;

  logic out_valid_r;

  // clamped configuration
  logic [lpac_pkg::PSIZE_W-1:0] ps_c;
  logic [NW-1:0]                ns_c;
  always_comb begin
    priority if (page_size == '0)               ps_c = lpac_pkg::PSIZE_W'(1);
    else if (page_size > lpac_pkg::PSIZE_MAX)   ps_c = lpac_pkg::PSIZE_MAX;
    else                                        ps_c = page_size;
    priority if (slots_in_use == '0)            ns_c = NW'(1);
    else if (NW'(slots_in_use) > NW'(NUM_SLOTS)) ns_c = NW'(NUM_SLOTS);
    else                                        ns_c = NW'(slots_in_use);
  end

  // one quotient bit per step
  logic [lpac_pkg::PSIZE_W-1:0] trial;
  logic                         ge;
  logic [lpac_pkg::PSIZE_W-1:0] diff;
  assign trial = {rem_r, quo_r[lpac_pkg::IDX_W-1]};
  assign ge    = (trial >= ps_r);
  assign diff  = trial - ps_r;

  // scan slot at sidx_r
  logic           in_use;
  logic           s_valid, s_dirty;
  logic [PW-1:0]  s_page;
  logic [STAMP_BITS-1:0] s_stamp;
  assign s_valid = sp_valid_r[sidx_r];
  assign s_page  = sp_page_r[sidx_r];
  assign s_dirty = sp_dirty_r[sidx_r];
  assign s_stamp = sp_stamp_r[sidx_r];
  assign in_use  = (NW'(sidx_r) < ns_r);

  logic oor;
  logic [PW-1:0] page_lo;
  assign oor     = (quo_r >= PAGE_LIM);
  assign page_lo = quo_r[PW-1:0];

  // commit decisions
  logic [SW-1:0] slot_sel;
  logic          evict;
  always_comb begin
    priority if (hit_r) slot_sel = hslot_r;
    else if (free_r)    slot_sel = fslot_r;
    else                slot_sel = bslot_r;
    evict = !oor && !hit_r && !free_r;
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;
  assign sts.out_free  = out_free;
  assign sts.div_last  = (dcnt_r == lpac_pkg::DIV_LAST);
  assign sts.scan_last = (sidx_r == SLOT_LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo_r  <= in_element_index;
      rem_r  <= '0;
      ps_r   <= ps_c;
      ns_r   <= ns_c;
      dcnt_r <= '0;
      sidx_r <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? diff[lpac_pkg::OFF_W-1:0] : trial[lpac_pkg::OFF_W-1:0];
      quo_r  <= {quo_r[lpac_pkg::IDX_W-2:0], ge};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.scan_step) begin
      if (!sts.scan_last) sidx_r <= sidx_r + 1'b1;
      if (s_valid && s_page == page_lo) begin
        hit_r   <= 1'b1;
        hslot_r <= sidx_r;
      end
      if (in_use && !s_valid && !free_r) begin
        free_r  <= 1'b1;
        fslot_r <= sidx_r;
      end
      // first slot seeds the minimum, lowest index wins ties
      if (sidx_r == '0 || (in_use && s_stamp < best_r)) begin
        best_r   <= s_stamp;
        bslot_r  <= sidx_r;
        bpage_r  <= s_page;
        bdirty_r <= s_dirty;
      end
    end
  end

  // slot state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        sp_valid_r[i] <= 1'b0;
        sp_dirty_r[i] <= 1'b0;
        sp_stamp_r[i] <= '0;
      end
      clock_r  <= '0;
      hits_r   <= '0;
      faults_r <= '0;
    end else if (cmd.commit && !oor) begin
      sp_dirty_r[slot_sel] <= 1'b1;
      if (hit_r) begin
        sp_stamp_r[slot_sel] <= clock_r;
        clock_r <= clock_r + 1'b1;
        if (hits_r != lpac_pkg::CNT_MAX) hits_r <= hits_r + 1'b1;
      end else begin
        // load tick then access tick
        sp_valid_r[slot_sel] <= 1'b1;
        sp_stamp_r[slot_sel] <= clock_r + 1'b1;
        clock_r <= clock_r + STAMP_BITS'(2);
        if (faults_r != lpac_pkg::CNT_MAX) faults_r <= faults_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !oor && !hit_r) sp_page_r[slot_sel] <= page_lo;
  end

  // result register
  logic [lpac_pkg::CNT_W-1:0] hits_nxt, faults_nxt;
  assign hits_nxt   = (!oor && hit_r && hits_r != lpac_pkg::CNT_MAX) ?
                      hits_r + 1'b1 : hits_r;
  assign faults_nxt = (!oor && !hit_r && faults_r != lpac_pkg::CNT_MAX) ?
                      faults_r + 1'b1 : faults_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_page_number      <= quo_r;
      out_page_offset      <= rem_r;
      out_ram_slot         <= oor ? '0 : lpac_pkg::SLOTO_W'(slot_sel);
      out_was_hit          <= !oor && hit_r;
      out_load_needed      <= !oor && !hit_r;
      out_writeback_needed <= evict && bdirty_r;
      out_victim_page      <= evict ? lpac_pkg::VICT_W'(bpage_r) : '0;
      out_hit_total        <= hits_nxt;
      out_fault_total      <= faults_nxt;
      out_out_of_range     <= oor;
    end
  end

  assign out_valid = out_valid_r;

endmodule
